// ----- rtl/glzw_pkg.sv -----
package glzw_pkg;

    localparam int TABLE_SIZE = 4096;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam int CODE_W     = ADDR_W + 1;
    localparam int ACC_W      = 19;
    localparam int MAX_WIDTH  = 12;

    localparam logic [CODE_W-1:0] NONE_CODE = CODE_W'(TABLE_SIZE);

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NEED     = 3'd1,
        ST_DONE     = 3'd2,
        ST_BAD_CODE = 3'd3,
        ST_EARLY    = 3'd4,
        ST_REJECT   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        RUN_START = 2'd0,
        RUN_GO    = 2'd1,
        RUN_FIN   = 2'd2,
        RUN_ERR   = 2'd3
    } run_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_WALK,
        S_WDATA,
        S_FIN
    } fsm_t;

    localparam logic CFG_ROOT  = 1'b0;
    localparam logic CFG_WIDTH = 1'b1;

endpackage

// ----- rtl/glzw_if.sv -----
interface glzw_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;

    modport source (output valid, func, data_byte, input ready);
    modport sink   (input valid, func, data_byte, output ready);
endinterface

interface glzw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       pixel_valid;
    logic       line_end;
    logic [2:0] status;

    modport source (output valid, pixel, pixel_valid, line_end, status, input ready);
    modport sink   (input valid, pixel, pixel_valid, line_end, status, output ready);
endinterface

// ----- rtl/glzw_ram.sv -----
module glzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/gif_lzw_decoder.sv -----
// A stacked pixel passes through S_POP, which reads the stack; a control answer
// is registered from the request. A code that expands through the tables walks
// S_WALK then S_WDATA per entry, each waiting on the registered read, then S_FIN.
// One request is in flight at a time; the result register must drain first.
// Reset (rst_n, asynchronous, active low) clears all control state; table and
// stack memories are not cleared and are written before they are read.
module gif_lzw_decoder (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [15:0]      cfg_wdata,
    glzw_in_if.sink          item,
    glzw_out_if.source       result
);

    localparam int AW = glzw_pkg::ADDR_W;
    localparam int CW = glzw_pkg::CODE_W;
    localparam int XW = glzw_pkg::ACC_W;

    glzw_pkg::fsm_t state_reg, state_next;
    glzw_pkg::run_t run_reg, run_next;
    glzw_pkg::status_t err_reg, err_next;

    logic [3:0]    root_reg;
    logic [15:0]   lw_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [XW-1:0] acc_reg, acc_next;
    logic [4:0]    bits_reg, bits_next;
    logic [3:0]    width_reg, width_next;
    logic [CW-1:0] nfc_reg, nfc_next;
    logic [CW-1:0] prev_reg, prev_next;
    logic [7:0]    fc_reg, fc_next;
    logic [15:0]   col_reg, col_next;
    logic [7:0]    left_reg, left_next;
    logic [CW-1:0] code_reg, code_next;
    logic [CW-1:0] cur_reg, cur_next;

    logic          ov_reg, ov_next;
    logic [7:0]    opix_reg, opix_next;
    logic          opv_reg, opv_next;
    logic          ole_reg, ole_next;
    logic [2:0]    ost_reg, ost_next;

    logic          stk_we;
    logic [AW-1:0] stk_waddr, stk_raddr;
    logic [7:0]    stk_wdata, stk_rdata;
    logic          tab_we;
    logic [AW-1:0] tab_raddr;
    logic [AW-1:0] pre_rdata;
    logic [7:0]    suf_rdata;

    logic          accept;
    logic [3:0]    eff_root;
    logic [CW-1:0] clear_code, eoi_code;
    logic [CW-1:0] mask;
    logic [CW-1:0] cur_code;
    logic [7:0]    fin_fc;
    logic [CW-1:0] nfc_inc;
    logic          respond, emit;
    logic [7:0]    emit_pix;
    logic [2:0]    resp_st;
    logic [16:0]   col_plus, lw_eff;

    assign item.ready = (state_reg == glzw_pkg::S_IDLE) && !ov_reg;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        if (root_reg < 4'd2)
        begin
            eff_root = 4'd2;
        end
        else if (root_reg > 4'd8)
        begin
            eff_root = 4'd8;
        end
        else
        begin
            eff_root = root_reg;
        end
    end

    assign clear_code = CW'(1) << eff_root;
    assign eoi_code   = clear_code + CW'(1);
    assign mask       = (CW'(1) << width_reg) - CW'(1);
    assign cur_code   = CW'(acc_reg[CW-1:0] & mask);
    assign fin_fc     = (cur_reg >= clear_code) ? 8'd0 : cur_reg[7:0];
    assign nfc_inc    = nfc_reg + CW'(1);
    assign col_plus   = {1'b0, col_reg} + 17'd1;
    assign lw_eff     = (lw_reg == 16'd0) ? 17'h10000 : {1'b0, lw_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= 4'd8;
            lw_reg   <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                glzw_pkg::CFG_ROOT:  root_reg <= cfg_wdata[3:0];
                glzw_pkg::CFG_WIDTH: lw_reg   <= cfg_wdata;
                default:             root_reg <= root_reg;
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            glzw_pkg::S_IDLE:
            begin
                if (accept && item.func && run_reg == glzw_pkg::RUN_GO)
                begin
                    if (count_reg != '0)
                    begin
                        state_next = glzw_pkg::S_POP;
                    end
                    else if ({1'b0, width_reg} <= bits_reg && cur_code != eoi_code
                             && cur_code != clear_code && cur_code <= nfc_reg
                             && prev_reg != glzw_pkg::NONE_CODE)
                    begin
                        state_next = glzw_pkg::S_WALK;
                    end
                end
            end
            glzw_pkg::S_POP:   state_next = glzw_pkg::S_IDLE;
            glzw_pkg::S_WALK:
            begin
                state_next = (cur_reg > clear_code) ? glzw_pkg::S_WDATA : glzw_pkg::S_FIN;
            end
            glzw_pkg::S_WDATA: state_next = glzw_pkg::S_WALK;
            glzw_pkg::S_FIN:
            begin
                state_next = (count_reg < CW'(glzw_pkg::TABLE_SIZE)) ?
                             glzw_pkg::S_IDLE : glzw_pkg::S_POP;
            end
            default:           state_next = glzw_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        run_next   = run_reg;
        err_next   = err_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        bits_next  = bits_reg;
        width_next = width_reg;
        nfc_next   = nfc_reg;
        prev_next  = prev_reg;
        fc_next    = fc_reg;
        left_next  = left_reg;
        code_next  = code_reg;
        cur_next   = cur_reg;
        stk_we     = 1'b0;
        stk_waddr  = count_reg[AW-1:0];
        stk_wdata  = fc_reg;
        stk_raddr  = AW'(count_reg - CW'(1));
        tab_we     = 1'b0;
        tab_raddr  = cur_reg[AW-1:0];
        respond    = 1'b0;
        emit       = 1'b0;
        emit_pix   = 8'd0;
        resp_st    = glzw_pkg::ST_OK;

        case (state_reg)
            glzw_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (run_reg == glzw_pkg::RUN_FIN)
                    begin
                        respond = 1'b1;
                        resp_st = glzw_pkg::ST_DONE;
                    end
                    else if (run_reg == glzw_pkg::RUN_ERR)
                    begin
                        respond = 1'b1;
                        resp_st = err_reg;
                    end
                    else if (!item.func)
                    begin
                        respond = 1'b1;
                        if (run_reg == glzw_pkg::RUN_START)
                        begin
                            if (item.data_byte == 8'd0)
                            begin
                                run_next = glzw_pkg::RUN_ERR;
                                err_next = glzw_pkg::ST_EARLY;
                                resp_st  = glzw_pkg::ST_EARLY;
                            end
                            else
                            begin
                                nfc_next   = clear_code + CW'(2);
                                prev_next  = glzw_pkg::NONE_CODE;
                                width_next = eff_root + 4'd1;
                                count_next = '0;
                                acc_next   = '0;
                                bits_next  = '0;
                                left_next  = item.data_byte;
                                run_next   = glzw_pkg::RUN_GO;
                            end
                        end
                        else if (count_reg != '0 || {1'b0, width_reg} <= bits_reg)
                        begin
                            resp_st = glzw_pkg::ST_REJECT;
                        end
                        else if (left_reg == 8'd0)
                        begin
                            if (item.data_byte == 8'd0)
                            begin
                                run_next = glzw_pkg::RUN_ERR;
                                err_next = glzw_pkg::ST_EARLY;
                                resp_st  = glzw_pkg::ST_EARLY;
                            end
                            else
                            begin
                                left_next = item.data_byte;
                            end
                        end
                        else
                        begin
                            acc_next  = acc_reg | (XW'(item.data_byte) << bits_reg);
                            bits_next = bits_reg + 5'd8;
                            left_next = left_reg - 8'd1;
                        end
                    end
                    else if (run_reg == glzw_pkg::RUN_START)
                    begin
                        respond = 1'b1;
                        resp_st = glzw_pkg::ST_NEED;
                    end
                    else if (count_reg != '0)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    else if ({1'b0, width_reg} > bits_reg)
                    begin
                        respond = 1'b1;
                        resp_st = glzw_pkg::ST_NEED;
                    end
                    else
                    begin
                        acc_next  = acc_reg >> width_reg;
                        bits_next = bits_reg - {1'b0, width_reg};
                        if (cur_code == eoi_code)
                        begin
                            respond  = 1'b1;
                            resp_st  = glzw_pkg::ST_DONE;
                            run_next = glzw_pkg::RUN_FIN;
                        end
                        else if (cur_code == clear_code)
                        begin
                            respond    = 1'b1;
                            nfc_next   = clear_code + CW'(2);
                            prev_next  = glzw_pkg::NONE_CODE;
                            width_next = eff_root + 4'd1;
                        end
                        else if (cur_code > nfc_reg)
                        begin
                            respond  = 1'b1;
                            resp_st  = glzw_pkg::ST_BAD_CODE;
                            run_next = glzw_pkg::RUN_ERR;
                            err_next = glzw_pkg::ST_BAD_CODE;
                        end
                        else if (prev_reg == glzw_pkg::NONE_CODE)
                        begin
                            respond = 1'b1;
                            if (cur_code > eoi_code)
                            begin
                                resp_st  = glzw_pkg::ST_BAD_CODE;
                                run_next = glzw_pkg::RUN_ERR;
                                err_next = glzw_pkg::ST_BAD_CODE;
                            end
                            else
                            begin
                                // The root code is pushed and popped at once.
                                emit      = 1'b1;
                                emit_pix  = cur_code[7:0];
                                fc_next   = cur_code[7:0];
                                prev_next = cur_code;
                            end
                        end
                        else
                        begin
                            code_next = cur_code;
                            if (cur_code == nfc_reg)
                            begin
                                stk_we     = 1'b1;
                                stk_wdata  = fc_reg;
                                count_next = CW'(1);
                                cur_next   = prev_reg;
                            end
                            else
                            begin
                                cur_next = cur_code;
                            end
                        end
                    end
                end
            end
            glzw_pkg::S_POP:
            begin
                respond  = 1'b1;
                emit     = 1'b1;
                emit_pix = stk_rdata;
            end
            glzw_pkg::S_WALK:
            begin
                tab_raddr = cur_reg[AW-1:0];
            end
            glzw_pkg::S_WDATA:
            begin
                if (count_reg < CW'(glzw_pkg::TABLE_SIZE))
                begin
                    stk_we     = 1'b1;
                    stk_wdata  = suf_rdata;
                    count_next = count_reg + CW'(1);
                end
                cur_next = CW'(pre_rdata);
            end
            glzw_pkg::S_FIN:
            begin
                fc_next   = fin_fc;
                prev_next = code_reg;
                if (nfc_reg < CW'(glzw_pkg::TABLE_SIZE))
                begin
                    tab_we   = 1'b1;
                    nfc_next = nfc_inc;
                    if ((nfc_inc & mask) == '0 && nfc_inc < CW'(glzw_pkg::TABLE_SIZE)
                        && width_reg < 4'(glzw_pkg::MAX_WIDTH))
                    begin
                        width_next = width_reg + 4'd1;
                    end
                end
                if (count_reg < CW'(glzw_pkg::TABLE_SIZE))
                begin
                    respond  = 1'b1;
                    emit     = 1'b1;
                    emit_pix = fin_fc;
                end
                else
                begin
                    stk_raddr  = AW'(count_reg - CW'(1));
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                respond = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        col_next  = col_reg;
        ov_next   = ov_reg && !result.ready;
        opix_next = opix_reg;
        opv_next  = opv_reg;
        ole_next  = ole_reg;
        ost_next  = ost_reg;
        if (respond)
        begin
            ov_next   = 1'b1;
            opix_next = emit ? emit_pix : 8'd0;
            opv_next  = emit;
            ole_next  = 1'b0;
            ost_next  = resp_st;
            if (emit)
            begin
                if (col_plus >= lw_eff)
                begin
                    ole_next = 1'b1;
                    col_next = 16'd0;
                end
                else
                begin
                    col_next = col_plus[15:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= glzw_pkg::S_IDLE;
            run_reg   <= glzw_pkg::RUN_START;
            err_reg   <= glzw_pkg::ST_OK;
            count_reg <= '0;
            acc_reg   <= '0;
            bits_reg  <= '0;
            width_reg <= 4'd9;
            nfc_reg   <= CW'(258);
            prev_reg  <= glzw_pkg::NONE_CODE;
            fc_reg    <= '0;
            col_reg   <= '0;
            left_reg  <= '0;
            code_reg  <= '0;
            cur_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            run_reg   <= run_next;
            err_reg   <= err_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
            bits_reg  <= bits_next;
            width_reg <= width_next;
            nfc_reg   <= nfc_next;
            prev_reg  <= prev_next;
            fc_reg    <= fc_next;
            col_reg   <= col_next;
            left_reg  <= left_next;
            code_reg  <= code_next;
            cur_reg   <= cur_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opix_reg <= opix_next;
        opv_reg  <= opv_next;
        ole_reg  <= ole_next;
        ost_reg  <= ost_next;
    end

    assign result.valid       = ov_reg;
    assign result.pixel       = opix_reg;
    assign result.pixel_valid = opv_reg;
    assign result.line_end    = ole_reg;
    assign result.status      = ost_reg;

    glzw_ram #(.WIDTH(8), .DEPTH(glzw_pkg::TABLE_SIZE)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    glzw_ram #(.WIDTH(AW), .DEPTH(glzw_pkg::TABLE_SIZE)) u_prefix (
        .clk   (clk),
        .we    (tab_we),
        .waddr (nfc_reg[AW-1:0]),
        .wdata (prev_reg[AW-1:0]),
        .raddr (tab_raddr),
        .rdata (pre_rdata)
    );

    glzw_ram #(.WIDTH(8), .DEPTH(glzw_pkg::TABLE_SIZE)) u_suffix (
        .clk   (clk),
        .we    (tab_we),
        .waddr (nfc_reg[AW-1:0]),
        .wdata (fin_fc),
        .raddr (tab_raddr),
        .rdata (suf_rdata)
    );

endmodule

// ----- rtl/glzw_checker.sv -----
module glzw_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       o_valid,
    input logic       o_ready,
    input logic [7:0] o_pixel,
    input logic       o_pixel_valid,
    input logic       o_line_end,
    input logic [2:0] o_status
);

    logic done_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_seen_reg <= 1'b0;
        end
        else if (o_valid && o_ready && o_status == glzw_pkg::ST_DONE)
        begin
            done_seen_reg <= 1'b1;
        end
    end

    // A finished result holds until the sink takes it.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid && !o_ready |=> o_valid && $stable(o_status) && $stable(o_pixel))
        else $error("result dropped or changed while stalled");

    a_lend: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid && o_line_end |-> o_pixel_valid)
        else $error("line end without a pixel");

    a_nopix: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid && !o_pixel_valid |-> o_pixel == 8'd0)
        else $error("pixel value without pixel_valid");

    a_pixok: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid && o_pixel_valid |-> o_status == glzw_pkg::ST_OK)
        else $error("pixel with a non-ok status");

    // Finished is sticky: once shown, no later result reports anything else.
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_seen_reg && o_valid |-> o_status == glzw_pkg::ST_DONE)
        else $error("result after the end code is not finished");

endmodule

bind gif_lzw_decoder glzw_checker u_glzw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .o_valid       (result.valid),
    .o_ready       (result.ready),
    .o_pixel       (result.pixel),
    .o_pixel_valid (result.pixel_valid),
    .o_line_end    (result.line_end),
    .o_status      (result.status)
);

// ----- bench/gif_lzw_checker.sv -----
`timescale 1ns / 100ps

module gif_lzw_checker
    import glzw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    glzw_in_if          req,
    glzw_out_if         rsp,
    output int          mismatches,
    output int          outstanding
);

    localparam logic FN_BYTE  = 1'b0;

    typedef struct packed {
        logic [7:0] pixel;
        logic       pixel_valid;
        logic       line_end;
        status_t    status;
    } pixel_result_t;

    pixel_result_t expected_pixels[$];

    logic [3:0]  root_reg;
    logic [15:0] width_reg;

    int      chain_prefix [TABLE_SIZE];
    int      chain_suffix [TABLE_SIZE];
    int      pixel_stack  [TABLE_SIZE];
    int      stack_depth;
    int      bit_acc;
    int      bits_held;
    int      code_width;
    int      next_code;
    int      prev_code;
    int      first_px;
    int      column;
    int      block_left;
    run_t    run;
    status_t sticky_status;

    assign outstanding = expected_pixels.size();

    function automatic int active_root();
        int r;
        r = root_reg;
        if (r < 2) r = 2;
        if (r > 8) r = 8;
        return r;
    endfunction

    task automatic restart_table();
        next_code  = (1 << active_root()) + 2;
        prev_code  = NONE_CODE;
        code_width = active_root() + 1;
    endtask

    task automatic push_pixel(input int v);
        if (stack_depth < TABLE_SIZE)
        begin
            pixel_stack[stack_depth] = v & 8'hFF;
            stack_depth++;
        end
    endtask

    task automatic fail_with(input status_t st);
        run           = RUN_ERR;
        sticky_status = st;
    endtask

    task automatic decode_code(output status_t st);
        int clear_c;
        int eoi_c;
        int c;
        int cur;
        int n;
        clear_c   = 1 << active_root();
        eoi_c     = clear_c + 1;
        c         = bit_acc & ((1 << code_width) - 1);
        bit_acc   = bit_acc >> code_width;
        bits_held = bits_held - code_width;
        st        = ST_OK;
        if (c == eoi_c)
        begin
            run = RUN_FIN;
            st  = ST_DONE;
        end
        else if (c == clear_c)
            restart_table();
        else if (c > next_code || c >= TABLE_SIZE)
        begin
            fail_with(ST_BAD_CODE);
            st = ST_BAD_CODE;
        end
        else if (prev_code == NONE_CODE)
        begin
            // Right after a clear only a root code may follow.
            if (c > eoi_c)
            begin
                fail_with(ST_BAD_CODE);
                st = ST_BAD_CODE;
            end
            else
            begin
                push_pixel(c);
                first_px  = c & 8'hFF;
                prev_code = c;
            end
        end
        else
        begin
            if (c == next_code)
            begin
                push_pixel(first_px);
                cur = prev_code;
            end
            else
                cur = c;
            for (n = 0; n < TABLE_SIZE && cur > clear_c && cur < TABLE_SIZE; n++)
            begin
                push_pixel(chain_suffix[cur]);
                cur = chain_prefix[cur];
            end
            if (cur >= clear_c) cur = 0;
            first_px = cur & 8'hFF;
            push_pixel(first_px);
            if (next_code < TABLE_SIZE)
            begin
                chain_prefix[next_code] = prev_code & 12'hFFF;
                chain_suffix[next_code] = first_px;
                next_code++;
                if ((next_code & ((1 << code_width) - 1)) == 0 &&
                    next_code < TABLE_SIZE && code_width < MAX_WIDTH)
                    code_width++;
            end
            prev_code = c;
        end
    endtask

    task automatic predict_pixel(input logic f, input logic [7:0] b,
                                 output pixel_result_t r);
        int      lw;
        status_t st;
        r  = '{pixel: 8'd0, pixel_valid: 1'b0, line_end: 1'b0, status: ST_OK};
        st = ST_OK;
        if (run == RUN_FIN)
            r.status = ST_DONE;
        else if (run == RUN_ERR)
            r.status = sticky_status;
        else if (f == FN_BYTE)
        begin
            if (run == RUN_START)
            begin
                if (b == 8'd0)
                begin
                    fail_with(ST_EARLY);
                    r.status = ST_EARLY;
                end
                else
                begin
                    restart_table();
                    stack_depth = 0;
                    bit_acc     = 0;
                    bits_held   = 0;
                    block_left  = b;
                    run         = RUN_GO;
                end
            end
            else if (stack_depth > 0 || bits_held >= code_width)
                r.status = ST_REJECT;
            else if (block_left == 0)
            begin
                if (b == 8'd0)
                begin
                    fail_with(ST_EARLY);
                    r.status = ST_EARLY;
                end
                else
                    block_left = b;
            end
            else
            begin
                bit_acc    = bit_acc | (int'(b) << bits_held);
                bits_held  = bits_held + 8;
                block_left = block_left - 1;
            end
        end
        else
        begin
            if (run == RUN_START || (stack_depth == 0 && bits_held < code_width))
                r.status = ST_NEED;
            else
            begin
                if (stack_depth == 0) decode_code(st);
                r.status = st;
                if (st == ST_OK && stack_depth > 0)
                begin
                    lw = (width_reg == 16'd0) ? 65536 : int'(width_reg);
                    stack_depth--;
                    r.pixel       = pixel_stack[stack_depth];
                    r.pixel_valid = 1'b1;
                    if (column + 1 >= lw)
                    begin
                        r.line_end = 1'b1;
                        column     = 0;
                    end
                    else
                        column = (column + 1) & 16'hFFFF;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t want;
        pixel_result_t got;
        if (!rst_n)
        begin
            expected_pixels.delete();
            mismatches    = 0;
            root_reg      = 4'd8;
            width_reg     = 16'd1;
            stack_depth   = 0;
            bit_acc       = 0;
            bits_held     = 0;
            first_px      = 0;
            column        = 0;
            block_left    = 0;
            run           = RUN_START;
            sticky_status = ST_OK;
            restart_table();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ROOT)
                    root_reg = cfg_wdata[3:0];
                else
                    width_reg = cfg_wdata;
            end
            if (req.valid && req.ready)
            begin
                predict_pixel(req.func, req.data_byte, want);
                expected_pixels.push_back(want);
            end
            if (rsp.valid && rsp.ready)
            begin
                got = '{pixel: rsp.pixel, pixel_valid: rsp.pixel_valid,
                        line_end: rsp.line_end, status: status_t'(rsp.status)};
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with no request pending: %s%0d %0b %0b %0d",
                                 $realtime, "pix/pv/le/st=", got.pixel,
                                 got.pixel_valid, got.line_end, got.status);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.pixel !== want.pixel || got.pixel_valid !== want.pixel_valid ||
                        got.line_end !== want.line_end || got.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch exp pix=%0d pv=%0b le=%0b st=%0d,",
                                      " got pix=%0d pv=%0b le=%0b st=%0d"},
                                     $realtime, want.pixel, want.pixel_valid,
                                     want.line_end, want.status, got.pixel,
                                     got.pixel_valid, got.line_end, got.status);
                    end
                end
            end
        end
    end

endmodule

// ----- bench/tb_gif_lzw_decoder.sv -----
`timescale 1ns / 100ps

module tb_gif_lzw_decoder;

    import glzw_pkg::*;

    localparam logic FN_BYTE    = 1'b0;
    localparam logic FN_FETCH   = 1'b1;
    localparam int   IDLE_LIMIT = 20000;
    localparam int   LONG_STALL = 400;
    localparam int   SETTLE     = 40;

    typedef enum int { OP_ITEM, OP_CFG, OP_DRAIN } op_kind_t;

    typedef struct {
        op_kind_t    kind;
        logic        func;
        logic [7:0]  value;
        logic        index;
        logic [15:0] wdata;
    } stim_op_t;

    typedef struct {
        int          value;
        int          width;
        int          fetches;
        bit          retune;
        logic [3:0]  root_cfg;
        logic [15:0] width_cfg;
    } lzw_code_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    int          mismatches;
    int          outstanding;
    int          idle_cycles = 0;
    int          results_seen = 0;
    bit          rx_fast = 1'b0;
    bit          tx_fast = 1'b0;

    glzw_in_if  item_ch ();
    glzw_out_if pixel_ch ();

    gif_lzw_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (pixel_ch)
    );

    gif_lzw_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .req         (item_ch),
        .rsp         (pixel_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    stim_op_t  ops[$];
    lzw_code_t codes[$];

    // Encoder dictionary plus a mirror of the decoder's code width tracking.
    int enc_prefix [TABLE_SIZE];
    int enc_suffix [TABLE_SIZE];
    int enc_len    [TABLE_SIZE];
    int enc_next;
    int cur_root;
    int dec_width;
    int dec_next;
    bit dec_first;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int clamp_root(int r);
        if (r < 2) return 2;
        if (r > 8) return 8;
        return r;
    endfunction

    function automatic logic [15:0] pick_line_width();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            default: return 16'($urandom_range(2, 24));
        endcase
    endfunction

    function automatic int string_len(int c);
        return (c < (1 << cur_root)) ? 1 : enc_len[c];
    endfunction

    task automatic add_item(input logic f, input logic [7:0] v);
        ops.push_back('{kind: OP_ITEM, func: f, value: v, index: 1'b0, wdata: 16'd0});
    endtask

    task automatic add_cfg(input logic idx, input logic [15:0] v);
        ops.push_back('{kind: OP_CFG, func: FN_BYTE, value: 8'd0, index: idx, wdata: v});
    endtask

    task automatic add_code(input int value, input int fetches, input bit retune,
                            input int root_cfg, input logic [15:0] width_cfg);
        int clear_c;
        clear_c = 1 << cur_root;
        codes.push_back('{value: value, width: dec_width, fetches: fetches,
                          retune: retune, root_cfg: 4'(root_cfg), width_cfg: width_cfg});
        if (value == clear_c)
        begin
            dec_next  = clear_c + 2;
            dec_width = cur_root + 1;
            dec_first = 1'b1;
        end
        else if (dec_first)
            dec_first = 1'b0;
        else if (dec_next < TABLE_SIZE)
        begin
            dec_next++;
            if ((dec_next & ((1 << dec_width) - 1)) == 0 && dec_next < TABLE_SIZE &&
                dec_width < MAX_WIDTH)
                dec_width++;
        end
    endtask

    task automatic encode_run(input int npix, input int alpha);
        int clear_c;
        int w;
        int k;
        int d;
        int hit;
        clear_c  = 1 << cur_root;
        enc_next = clear_c + 2;
        w        = $urandom_range(0, alpha - 1);
        k        = w;
        for (int i = 1; i < npix; i++)
        begin
            if ($urandom_range(0, 1) == 0) k = $urandom_range(0, alpha - 1);
            hit = -1;
            for (d = clear_c + 2; d < enc_next; d++)
                if (enc_prefix[d] == w && enc_suffix[d] == k) hit = d;
            if (hit >= 0)
                w = hit;
            else
            begin
                add_code(w, string_len(w), 1'b0, 0, 16'd0);
                if ($urandom_range(0, 59) == 0)
                begin
                    add_code(clear_c, 1, 1'b0, 0, 16'd0);
                    enc_next = clear_c + 2;
                end
                else if (enc_next < TABLE_SIZE)
                begin
                    enc_prefix[enc_next] = w;
                    enc_suffix[enc_next] = k;
                    enc_len[enc_next]    = string_len(w) + 1;
                    enc_next++;
                end
                w = k;
            end
        end
        add_code(w, string_len(w), 1'b0, 0, 16'd0);
    endtask

    task automatic build_stream();
        int          root_val;
        int          alpha;
        int          ending;
        int          value;
        int          left;
        int          len;
        int          ci;
        int          end_bit;
        longint      acc;
        int          nb;
        int          total;
        bit          first_done;
        logic [7:0]  stream_bytes[$];
        int          code_end[$];

        root_val = $urandom_range(0, 15);
        add_cfg(CFG_ROOT, 16'(root_val));
        add_cfg(CFG_WIDTH, pick_line_width());
        // A fetch before the first length byte has nothing to give.
        add_item(FN_FETCH, 8'd0);
        ending = $urandom_range(0, 15);
        if (ending == 15)
        begin
            // A zero first length ends the stream; the rest must stay in error.
            add_item(FN_BYTE, 8'd0);
            for (int i = 0; i < 6; i++) add_item(1'($urandom_range(0, 1)), 8'($urandom));
        end

        cur_root  = clamp_root(root_val);
        dec_width = cur_root + 1;
        dec_next  = (1 << cur_root) + 2;
        dec_first = 1'b1;
        add_code(1 << cur_root, 1, 1'b0, 0, 16'd0);
        for (int p = 0; p < 4; p++)
        begin
            if (p > 0)
            begin
                // The new clear code is cut at the decoder's current width.
                do root_val = $urandom_range(0, 15);
                while (clamp_root(root_val) > dec_width - 1);
                cur_root = clamp_root(root_val);
                add_code(1 << cur_root, 1, 1'b1, root_val, pick_line_width());
            end
            alpha = ($urandom_range(0, 3) == 0) ? (1 << cur_root) : $urandom_range(1, 4);
            encode_run($urandom_range(60, 140), alpha);
        end

        value = 1 << cur_root;
        if (ending < 7)
            add_code(value + 1, 1, 1'b0, 0, 16'd0);
        else if (ending < 10 && dec_next + 1 < (1 << dec_width))
            add_code($urandom_range(dec_next + 1, (1 << dec_width) - 1), 1, 1'b0, 0, 16'd0);
        else if (ending < 13)
        begin
            add_code(value, 1, 1'b0, 0, 16'd0);
            add_code($urandom_range(value + 2, (1 << dec_width) - 1), 1, 1'b0, 0, 16'd0);
        end

        acc = 0;
        nb  = 0;
        end_bit = 0;
        foreach (codes[i])
        begin
            acc = acc | (longint'(codes[i].value) << nb);
            nb += codes[i].width;
            end_bit += codes[i].width;
            code_end.push_back(end_bit);
            while (nb >= 8)
            begin
                stream_bytes.push_back(acc[7:0]);
                acc = acc >> 8;
                nb -= 8;
            end
        end
        if (nb > 0) stream_bytes.push_back(acc[7:0]);

        total = stream_bytes.size();
        left  = 0;
        ci    = 0;
        foreach (stream_bytes[bi])
        begin
            if (left == 0)
            begin
                len = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(1, 12);
                if (len > total - bi) len = total - bi;
                add_item(FN_BYTE, 8'(len));
                left = len;
            end
            add_item(FN_BYTE, stream_bytes[bi]);
            left--;
            first_done = 1'b0;
            while (ci < codes.size() && code_end[ci] <= 8 * (bi + 1))
            begin
                // A byte offered while a whole code waits must bounce.
                if (!first_done && $urandom_range(0, 5) == 0)
                    add_item(FN_BYTE, 8'($urandom));
                first_done = 1'b1;
                if (codes[ci].retune)
                begin
                    add_cfg(CFG_ROOT, 16'(codes[ci].root_cfg));
                    add_cfg(CFG_WIDTH, codes[ci].width_cfg);
                end
                for (int f = 0; f < codes[ci].fetches; f++) add_item(FN_FETCH, 8'd0);
                ci++;
            end
            if ($urandom_range(0, 7) == 0) add_item(FN_FETCH, 8'($urandom));
        end
        // Block terminator: ends the stream early unless an end code or a bad code came first.
        add_item(FN_BYTE, 8'd0);
        for (int i = 0; i < 6; i++) add_item(1'($urandom_range(0, 1)), 8'($urandom));
    endtask

    task automatic wait_all_results();
        item_ch.valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic send_item(input logic f, input logic [7:0] v);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid     = 1'b1;
        item_ch.func      = f;
        item_ch.data_byte = v;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (pixel_ch.valid && pixel_ch.ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: random back-pressure with one long hold-off.
    initial
    begin
        int gap;
        pixel_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (results_seen % 60 == 0) rx_fast = ($urandom_range(0, 2) == 0);
            gap = rx_fast ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                pixel_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            if (results_seen == 80)
            begin
                pixel_ch.ready = 1'b0;
                repeat (LONG_STALL) @(negedge clk);
            end
            pixel_ch.ready = 1'b1;
            @(posedge clk);
            while (!pixel_ch.valid) @(posedge clk);
            results_seen++;
        end
    end

    initial
    begin
        item_ch.valid     = 1'b0;
        item_ch.func      = FN_BYTE;
        item_ch.data_byte = 8'd0;
        build_stream();
        ops.insert(ops.size() / 2, '{kind: OP_DRAIN, func: FN_BYTE, value: 8'd0,
                                     index: 1'b0, wdata: 16'd0});
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (ops[i])
        begin
            if (i % 50 == 0) tx_fast = ($urandom_range(0, 2) == 0);
            case (ops[i].kind)
                OP_ITEM:
                    send_item(ops[i].func, ops[i].value);
                OP_DRAIN:
                    wait_all_results();
                OP_CFG:
                begin
                    wait_all_results();
                    cfg_we    = 1'b1;
                    cfg_index = ops[i].index;
                    cfg_wdata = ops[i].wdata;
                    @(negedge clk);
                    cfg_we = 1'b0;
                end
            endcase
        end
        wait_all_results();
        repeat (SETTLE) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- gif_lzw_decoder.f -----
rtl/glzw_pkg.sv
rtl/glzw_if.sv
rtl/glzw_ram.sv
rtl/gif_lzw_decoder.sv
rtl/glzw_checker.sv
bench/gif_lzw_checker.sv
bench/tb_gif_lzw_decoder.sv
